@@ rtl/trapezoid_squeeze_shade_warp_top_defines.svh @@
`ifndef TRAPEZOID_SQUEEZE_SHADE_WARP_TOP_DEFINES_SVH
`define TRAPEZOID_SQUEEZE_SHADE_WARP_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define TSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tsw_pkg.sv @@
package tsw_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned FRAC_BITS  = 16;

  localparam int unsigned XW     = 8;              // coordinate / channel width
  localparam int unsigned DIMW   = 9;              // image dimension width
  localparam int unsigned FW     = FRAC_BITS + 1;  // fraction register width
  localparam int unsigned ONE    = 1 << FRAC_BITS;
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W   = REG_IDX_W + 2;

  localparam logic [FW-1:0]   AMOUNT_RST  = FW'((ONE * 4 + 2) / 5);
  localparam logic [FW-1:0]   SHORTEN_RST = FW'((ONE * 7 + 5) / 10);
  localparam logic [DIMW-1:0] WIDTH_RST   = DIMW'(MAX_WIDTH);
  localparam logic [DIMW-1:0] HEIGHT_RST  = DIMW'(MAX_HEIGHT);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SIDE    = 3'd0,
    REG_AMOUNT  = 3'd1,
    REG_SHORTEN = 3'd2,
    REG_SHADOW  = 3'd3,
    REG_SRC_W   = 3'd4,
    REG_SRC_H   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_INSIDE     = 2'd0,
    ST_BACKGROUND = 2'd1,
    ST_OUTSIDE    = 2'd2
  } pix_status_e;

  typedef struct packed {
    logic          req_type;
    logic [XW-1:0] pix_x;
    logic [XW-1:0] pix_y;
    logic [XW-1:0] in_red;
    logic [XW-1:0] in_green;
    logic [XW-1:0] in_blue;
    logic [XW-1:0] in_alpha;
  } req_t;

  typedef struct packed {
    logic [XW-1:0] out_red;
    logic [XW-1:0] out_green;
    logic [XW-1:0] out_blue;
    logic [XW-1:0] out_alpha;
    logic [1:0]    pixel_status;
  } rsp_t;

endpackage

@@ rtl/tsw_stream_if.sv @@
interface tsw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tsw_ram.sv @@
module tsw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end
endmodule

@@ rtl/tsw_div.sv @@
module tsw_div #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 26,
  parameter int unsigned QW = 9
) (
  input  logic          clk_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o
);
  // restoring division, one quotient bit per stage
  localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [CW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [CW-1:0] trial;
    logic [CW:0]   diff;
    logic [QW-1:0] quo_nx;

    if (k == 0) begin : g_first
      assign rem_in = CW'(n_i);
      assign den_in = d_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = CW'(den_in) << (QW - 1 - k);
    assign diff  = {1'b0, rem_in} - {1'b0, trial};

    always_comb begin
      quo_nx = quo_in;
      quo_nx[QW-1-k] = ~diff[CW];
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= diff[CW] ? rem_in : diff[CW-1:0];
      den_q[k] <= den_in;
      quo_q[k] <= quo_nx;
    end
  end

  assign q_o = quo_q[QW-1];
endmodule

@@ rtl/trapezoid_squeeze_shade_warp_top.sv @@
// channel | dir | handshake      | payload
// req_i   | in  | valid / ready  | req_t: load pixel or read destination pixel
// rsp_o   | out | valid / ready  | rsp_t: shaded rgba and pixel status, reads only
// apb     | in  | psel / penable | six config registers at byte address 4*index
//
// one transaction per cycle sustained on req_i while read credits are free
// a read passes three pipelined divider groups (column height with source column,
// source row, shading) and the registered frame store read between them
// up to 32 reads may be outstanding; a 32-deep result fifo holds them when rsp_o stalls
// rst_ni clears control and config; the frame store content stays undefined
`include "trapezoid_squeeze_shade_warp_top_defines.svh"

module trapezoid_squeeze_shade_warp_top import tsw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  tsw_stream_if.sink         req_i,
  tsw_stream_if.source       rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int unsigned DENW = DIMW + FRAC_BITS;   // destw * ONE
  localparam int unsigned HN_W = DIMW + DENW + 1;    // 2*h*t + den
  localparam int unsigned WX_W = DIMW + XW;          // src_width * x
  localparam int unsigned SN_W = XW + DENW + 1;      // 2*chan*scale + den
  localparam int unsigned L1   = DIMW;               // height divider latency
  localparam int unsigned L2   = XW;                 // row divider latency
  localparam int unsigned L3   = XW;                 // shading divider latency
  localparam int unsigned FIFO_DEPTH = 32;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // sideband riding along with each divider group
  typedef struct packed {
    req_t            item;
    logic            oob;
    logic [DENW-1:0] scale;
  } sb1_t;

  typedef struct packed {
    req_t            item;
    logic [1:0]      status;
    logic [DENW-1:0] scale;
    logic [XW-1:0]   srci;
  } sb2_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [XW-1:0] alpha;
  } sb3_t;

  function automatic logic [FW-1:0] clamp_frac(logic [31:0] v);
    return (v > 32'(ONE)) ? FW'(ONE) : v[FW-1:0];
  endfunction

  function automatic logic [DIMW-1:0] clamp_dim(logic [31:0] v, logic [31:0] hi);
    logic [DIMW-1:0] r;
    if (v == 32'd0) begin
      r = DIMW'(1);
    end else if (v > hi) begin
      r = hi[DIMW-1:0];
    end else begin
      r = v[DIMW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic            side_q;
  logic [FW-1:0]   amt_q, shf_q, shd_q;
  logic [DIMW-1:0] w_q, h_q;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 1'b1;
      amt_q  <= AMOUNT_RST;
      shf_q  <= SHORTEN_RST;
      shd_q  <= '0;
      w_q    <= WIDTH_RST;
      h_q    <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SIDE:    side_q <= pwdata[0];
        REG_AMOUNT:  amt_q  <= clamp_frac(pwdata);
        REG_SHORTEN: shf_q  <= clamp_frac(pwdata);
        REG_SHADOW:  shd_q  <= clamp_frac(pwdata);
        REG_SRC_W:   w_q    <= clamp_dim(pwdata, 32'(MAX_WIDTH));
        REG_SRC_H:   h_q    <= clamp_dim(pwdata, 32'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SIDE:    prdata = 32'(side_q);
      REG_AMOUNT:  prdata = 32'(amt_q);
      REG_SHORTEN: prdata = 32'(shf_q);
      REG_SHADOW:  prdata = 32'(shd_q);
      REG_SRC_W:   prdata = 32'(w_q);
      REG_SRC_H:   prdata = 32'(h_q);
      default:     prdata = '0;
    endcase
  end

  // destination width, round(src_width * shorten), refreshed every cycle
  logic [DIMW+FW-1:0] destw_sum;
  logic [DIMW-1:0]    destw_q;
  logic [DENW-1:0]    den;
  logic [FW-1:0]      onema;

  assign destw_sum = (DIMW+FW)'(w_q) * (DIMW+FW)'(shf_q) + (DIMW+FW)'(ONE >> 1);
  assign den       = {destw_q, FRAC_BITS'(0)};
  assign onema     = FW'(ONE) - amt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      destw_q <= '0;
    end else begin
      destw_q <= destw_sum[FRAC_BITS +: DIMW];
    end
  end

  // ---------------------------------------------------------------------------
  // input stage and result credits
  // ---------------------------------------------------------------------------
  logic               acc, take_read, pop, push;
  logic [FIFO_AW:0]   cred_q;
  logic [FIFO_AW:0]   fifo_cnt_q;

  assign acc         = req_i.valid && req_i.ready;
  assign take_read   = acc && (req_i.data.req_type == REQ_READ);
  assign req_i.ready = cred_q < (FIFO_AW+1)'(FIFO_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
    end else begin
      cred_q <= cred_q + (FIFO_AW+1)'(take_read) - (FIFO_AW+1)'(pop);
    end
  end

  logic a_v_q;
  req_t a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_q <= req_i.data;
    end
  end

  // stage a: distance from the chosen side, bounds, first products
  logic            a_oob;
  logic [XW-1:0]   a_p;
  logic [DIMW-1:0] a_pl;

  assign a_pl  = destw_q - DIMW'(1) - DIMW'(a_q.pix_x);
  assign a_p   = side_q ? a_q.pix_x : a_pl[XW-1:0];
  assign a_oob = (destw_q == '0) || (DIMW'(a_q.pix_x) >= destw_q) ||
                 (DIMW'(a_q.pix_y) >= h_q);

  logic            b_v_q;
  req_t            b_item_q;
  logic            b_oob_q;
  logic [DENW-1:0] b_t_q, b_scale_q;
  logic [WX_W-1:0] b_wx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_item_q  <= a_q;
    b_oob_q   <= a_oob;
    b_t_q     <= den - DENW'(onema) * DENW'(a_p);
    b_scale_q <= den - DENW'(shd_q) * DENW'(a_p);
    b_wx_q    <= WX_W'(w_q) * WX_W'(a_q.pix_x);
  end

  // stage b: column height and source column dividers
  logic [HN_W-1:0] hn;
  logic [DIMW-1:0] desth, srci9;

  assign hn = ((HN_W'(h_q) * HN_W'(b_t_q)) << 1) + HN_W'(den);

  tsw_div #(.NW(HN_W), .DW(DENW + 1), .QW(L1)) u_div_h (
    .clk_i (clk_i),
    .n_i   (hn),
    .d_i   ({den, 1'b0}),
    .q_o   (desth)
  );

  tsw_div #(.NW(WX_W), .DW(DIMW), .QW(L1)) u_div_i (
    .clk_i (clk_i),
    .n_i   (b_wx_q),
    .d_i   (destw_q),
    .q_o   (srci9)
  );

  logic [L1-1:0] v1_q;
  sb1_t          sb1_q [L1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= '0;
    end else begin
      v1_q <= {v1_q[L1-2:0], b_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    sb1_q[0] <= '{item: b_item_q, oob: b_oob_q, scale: b_scale_q};
    for (int i = 1; i < L1; i++) begin
      sb1_q[i] <= sb1_q[i-1];
    end
  end

  // stage c: centring and column membership
  sb1_t            c_sb;
  logic [DIMW-1:0] c_hm;
  logic [XW-1:0]   c_j0, c_ydiff;
  logic [DIMW:0]   c_yend;
  logic            c_in;
  logic [1:0]      c_status;

  assign c_sb    = sb1_q[L1-1];
  assign c_hm    = h_q - desth;
  assign c_j0    = c_hm[DIMW-1:1];
  assign c_yend  = (DIMW+1)'(c_j0) + (DIMW+1)'(desth);
  assign c_in    = (desth != '0) && (c_sb.item.pix_y >= c_j0) &&
                   ((DIMW+1)'(c_sb.item.pix_y) < c_yend);
  assign c_ydiff = c_sb.item.pix_y - c_j0;

  always_comb begin
    priority if (c_sb.oob) begin
      c_status = ST_OUTSIDE;
    end else if (!c_in) begin
      c_status = ST_BACKGROUND;
    end else begin
      c_status = ST_INSIDE;
    end
  end

  logic            d_v_q;
  sb2_t            d_sb_q;
  logic [DIMW-1:0] d_desth_q;
  logic [WX_W-1:0] d_hy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else begin
      d_v_q <= v1_q[L1-1];
    end
  end

  always_ff @(posedge clk_i) begin
    d_sb_q    <= '{item: c_sb.item, status: c_status, scale: c_sb.scale,
                   srci: srci9[XW-1:0]};
    d_desth_q <= desth;
    d_hy_q    <= WX_W'(h_q) * WX_W'(c_ydiff);
  end

  // stage d: source row divider
  logic [XW-1:0] srcj;

  tsw_div #(.NW(WX_W), .DW(DIMW), .QW(L2)) u_div_j (
    .clk_i (clk_i),
    .n_i   (d_hy_q),
    .d_i   (d_desth_q),
    .q_o   (srcj)
  );

  logic [L2-1:0] v2_q;
  sb2_t          sb2_q [L2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= '0;
    end else begin
      v2_q <= {v2_q[L2-2:0], d_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    sb2_q[0] <= d_sb_q;
    for (int i = 1; i < L2; i++) begin
      sb2_q[i] <= sb2_q[i-1];
    end
  end

  // stage e: frame store, loads and reads meet here in order
  sb2_t              e_in;
  logic              ram_en, ram_we;
  logic [31:0]       ram_lin;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0]       ram_wdata, ram_rdata;

  assign e_in      = sb2_q[L2-1];
  assign ram_we    = (e_in.item.req_type == REQ_LOAD) &&
                     (32'(e_in.item.pix_x) < 32'(MAX_WIDTH)) &&
                     (32'(e_in.item.pix_y) < 32'(MAX_HEIGHT));
  assign ram_en    = v2_q[L2-1];
  assign ram_lin   = (e_in.item.req_type == REQ_LOAD)
                   ? 32'(e_in.item.pix_y) * 32'(MAX_WIDTH) + 32'(e_in.item.pix_x)
                   : 32'(srcj) * 32'(MAX_WIDTH) + 32'(e_in.srci);
  assign ram_addr  = ram_lin[ADDR_W-1:0];
  assign ram_wdata = {e_in.item.in_alpha, e_in.item.in_blue, e_in.item.in_green,
                      e_in.item.in_red};

  tsw_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_frame_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic            e_v_q;
  logic [1:0]      e_status_q;
  logic [DENW-1:0] e_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else begin
      e_v_q <= v2_q[L2-1] && (e_in.item.req_type == REQ_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    e_status_q <= e_in.status;
    e_scale_q  <= e_in.scale;
  end

  // stage f: shading numerators 2*chan*scale + den
  logic            f_v_q;
  sb3_t            f_sb_q;
  logic [SN_W-1:0] f_n_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_sb_q <= '{status: e_status_q, alpha: ram_rdata[31:24]};
    for (int k = 0; k < 3; k++) begin
      f_n_q[k] <= ((SN_W'(ram_rdata[8*k +: XW]) * SN_W'(e_scale_q)) << 1) + SN_W'(den);
    end
  end

  logic [XW-1:0] shade [3];

  for (genvar k = 0; k < 3; k++) begin : g_shade
    tsw_div #(.NW(SN_W), .DW(DENW + 1), .QW(L3)) u_div_s (
      .clk_i (clk_i),
      .n_i   (f_n_q[k]),
      .d_i   ({den, 1'b0}),
      .q_o   (shade[k])
    );
  end

  logic [L3-1:0] v3_q;
  sb3_t          sb3_q [L3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= '0;
    end else begin
      v3_q <= {v3_q[L3-2:0], f_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    sb3_q[0] <= f_sb_q;
    for (int i = 1; i < L3; i++) begin
      sb3_q[i] <= sb3_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // result fifo
  // ---------------------------------------------------------------------------
  sb3_t               g_sb;
  logic               g_inside;
  rsp_t               g_rsp;
  rsp_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;

  assign g_sb     = sb3_q[L3-1];
  assign g_inside = (g_sb.status == ST_INSIDE);
  assign push     = v3_q[L3-1];
  assign g_rsp    = '{out_red:      g_inside ? shade[0] : '0,
                      out_green:    g_inside ? shade[1] : '0,
                      out_blue:     g_inside ? shade[2] : '0,
                      out_alpha:    g_inside ? g_sb.alpha : '0,
                      pixel_status: g_sb.status};

  assign rsp_o.valid = (fifo_cnt_q != '0);
  assign rsp_o.data  = fifo_q[rd_ptr_q];
  assign pop         = rsp_o.valid && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= g_rsp;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `TSW_ASSERT_IMP(a_cred_bound, 1'b1, cred_q <= (FIFO_AW+1)'(FIFO_DEPTH), "credits above fifo depth")
  `TSW_ASSERT_IMP(a_fifo_in_cred, 1'b1, fifo_cnt_q <= cred_q, "fifo holds more than outstanding reads")
  `TSW_ASSERT_IMP(a_no_overflow, push, fifo_cnt_q < (FIFO_AW+1)'(FIFO_DEPTH), "push into full fifo")
  `TSW_ASSERT_IMP(a_bg_zero, rsp_o.valid && (rsp_o.data.pixel_status != ST_INSIDE), (rsp_o.data.out_alpha == '0) && (rsp_o.data.out_red == '0), "nonzero pixel outside column")
  `TSW_ASSERT_NXT(a_cred_drop, pop && !take_read, cred_q == $past(cred_q) - (FIFO_AW+1)'(1), "credit not returned on pop")

endmodule

@@ dv/tb_trapezoid_squeeze_shade_warp_top.sv @@
module tb_trapezoid_squeeze_shade_warp_top;
  import tsw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
  localparam logic [FW-1:0] FRAC_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  // apb side
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata, prdata;
  logic               pready;

  tsw_stream_if #(.payload_t(req_t)) req_ch ();
  tsw_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  trapezoid_squeeze_shade_warp_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the block's registers, already saturated
  logic            side_right_q;
  longint unsigned amount_q, shorten_q, shadow_q, width_q, height_q;

  // shadow frame store; only entries that were loaded are ever sampled
  logic [31:0] pixel_mem [STORE_DEPTH];
  bit          pixel_loaded [STORE_DEPTH];

  rsp_t pending_pixels [$];

  int unsigned mismatches, loads_sent, reads_sent, pixels_seen, cfg_writes;
  bit          idle_off;      // long stretch with no idling on either side
  int unsigned hold_left;     // receiver hold-off, counted down in its own process
  int unsigned status_seen [3];

  // ---------------------------------------------------------------------------
  // destination pixel predictor
  // ---------------------------------------------------------------------------
  function automatic rsp_t shade_pixel(input logic [XW-1:0] x, input logic [XW-1:0] y,
                                       output int unsigned addr, output bit from_store);
    longint unsigned destw, p, den, desth, j0, num, scale, si, sj;
    logic [31:0] word;
    rsp_t r;
    r = '0;
    addr = 0;
    from_store = 1'b0;
    destw = (width_q * shorten_q + (ONE >> 1)) >> FRAC_BITS;
    if (destw == 0 || x >= destw || y >= height_q) begin
      r.pixel_status = ST_OUTSIDE;
      return r;
    end
    p = side_right_q ? longint'(x) : destw - 1 - x;
    den = destw * ONE;
    num = height_q * den - height_q * (ONE - amount_q) * p;
    desth = (2 * num + den) / (2 * den);
    j0 = (height_q - desth) / 2;
    if (desth == 0 || y < j0 || y >= j0 + desth) begin
      r.pixel_status = ST_BACKGROUND;
      return r;
    end
    si = width_q * x / destw;
    sj = height_q * (y - j0) / desth;
    addr = int'((sj * MAX_WIDTH + si) % STORE_DEPTH);
    from_store = 1'b1;
    word = pixel_mem[addr];
    scale = den - shadow_q * p;
    r.out_red   = XW'((2 * longint'(word[7:0]) * scale + den) / (2 * den));
    r.out_green = XW'((2 * longint'(word[15:8]) * scale + den) / (2 * den));
    r.out_blue  = XW'((2 * longint'(word[23:16]) * scale + den) / (2 * den));
    r.out_alpha = word[31:24];
    r.pixel_status = ST_INSIDE;
    return r;
  endfunction

  function automatic longint unsigned sat_frac(input longint unsigned v);
    return (v > 64'(ONE)) ? 64'(ONE) : v;
  endfunction

  function automatic longint unsigned sat_dim(input longint unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > 64'(hi)) return 64'(hi);
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  task automatic send_item(input req_t item);
    int unsigned addr;
    bit from_store;
    rsp_t want;
    while (!idle_off && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do @(posedge clk_i); while (!req_ch.ready);
    // transaction accepted at this edge
    if (item.req_type == REQ_LOAD) begin
      addr = int'(item.pix_y) * MAX_WIDTH + int'(item.pix_x);
      pixel_mem[addr] = {item.in_alpha, item.in_blue, item.in_green, item.in_red};
      pixel_loaded[addr] = 1'b1;
      loads_sent++;
    end else begin
      want = shade_pixel(item.pix_x, item.pix_y, addr, from_store);
      pending_pixels.push_back(want);
      status_seen[want.pixel_status]++;
      reads_sent++;
    end
  endtask

  task automatic load_pixel(input logic [XW-1:0] x, input logic [XW-1:0] y,
                            input logic [31:0] rgba);
    req_t item;
    item.req_type = REQ_LOAD;
    item.pix_x = x;
    item.pix_y = y;
    {item.in_alpha, item.in_blue, item.in_green, item.in_red} = rgba;
    send_item(item);
  endtask

  // reads whose sample was never loaded get a load of random content first
  task automatic read_pixel(input logic [XW-1:0] x, input logic [XW-1:0] y);
    req_t item;
    int unsigned addr;
    bit from_store;
    rsp_t unused;
    unused = shade_pixel(x, y, addr, from_store);
    if (from_store && !pixel_loaded[addr])
      load_pixel(XW'(addr % MAX_WIDTH), XW'(addr / MAX_WIDTH), $urandom());
    item = req_t'({$urandom(), $urandom()});   // pixel fields of a read are don't-care
    item.req_type = REQ_READ;
    item.pix_x = x;
    item.pix_y = y;
    send_item(item);
  endtask

  task automatic stop_stream();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every outstanding read, then let the pipeline settle
  task automatic drain_pipeline();
    stop_stream();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_SIDE:    side_right_q = value[0];
      REG_AMOUNT:  amount_q  = sat_frac(64'(value));
      REG_SHORTEN: shorten_q = sat_frac(64'(value));
      REG_SHADOW:  shadow_q  = sat_frac(64'(value));
      REG_SRC_W:   width_q   = sat_dim(64'(value), MAX_WIDTH);
      REG_SRC_H:   height_q  = sat_dim(64'(value), MAX_HEIGHT);
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic side, input logic [31:0] amount,
                              input logic [31:0] shorten, input logic [31:0] shadow,
                              input logic [31:0] w, input logic [31:0] h);
    write_reg(REG_SIDE, 32'(side));
    write_reg(REG_AMOUNT, amount);
    write_reg(REG_SHORTEN, shorten);
    write_reg(REG_SHADOW, shadow);
    write_reg(REG_SRC_W, w);
    write_reg(REG_SRC_H, h);
  endtask

  function automatic int unsigned dest_width();
    return int'((width_q * shorten_q + (ONE >> 1)) >> FRAC_BITS);
  endfunction

  // ---------------------------------------------------------------------------
  // response side: ready with random stalls, hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      rsp_ch.ready <= idle_off || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // result checker, compares against the oldest expected pixel
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pixel result %h", $realtime, rsp_ch.data);
      end else begin
        want = pending_pixels.pop_front();
        if (rsp_ch.data.out_red !== want.out_red ||
            rsp_ch.data.out_green !== want.out_green ||
            rsp_ch.data.out_blue !== want.out_blue ||
            rsp_ch.data.out_alpha !== want.out_alpha ||
            rsp_ch.data.pixel_status !== want.pixel_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: pixel %0d expected rgba %h/%h/%h/%h st %0d, got %h/%h/%h/%h st %0d",
                     $realtime, pixels_seen, want.out_red, want.out_green, want.out_blue,
                     want.out_alpha, want.pixel_status, rsp_ch.data.out_red,
                     rsp_ch.data.out_green, rsp_ch.data.out_blue, rsp_ch.data.out_alpha,
                     rsp_ch.data.pixel_status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: 256x256 source, 0.7 width, 0.8 far height, no shade, squeeze right
  task automatic test_reset_geometry();
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd0, 8'd255);
    read_pixel(8'd178, 8'd128);       // last destination column, short
    read_pixel(8'd178, 8'd0);         // above the short column: background
    read_pixel(8'd179, 8'd10);        // first column past destination width
    read_pixel(8'd255, 8'd255);
    drain_pipeline();
  endtask

  // channel extremes, full shading, both sides
  task automatic test_shading_extremes();
    set_geometry(1'b0, ONE / 2, ONE, ONE, 8, 8);
    load_pixel(8'd0, 8'd0, 32'hFFFF_FFFF);
    load_pixel(8'd7, 8'd0, 32'h0000_0000);
    load_pixel(8'd7, 8'd4, 32'h80FF_01FE);
    read_pixel(8'd0, 8'd0);           // far column, above its shortened span
    read_pixel(8'd7, 8'd4);           // near column, no shade
    read_pixel(8'd3, 8'd3);
    drain_pipeline();
    write_reg(REG_SIDE, 32'(1));
    for (int x = 0; x < 8; x++) read_pixel(XW'(x), XW'(x));
    drain_pipeline();
  endtask

  // saturating and degenerate register values, unmapped addresses ignored
  task automatic test_register_corners();
    // fractions above one saturate; width 0 saturates to one pixel
    set_geometry(1'b1, 32'(FRAC_MAX), 32'(FRAC_MAX), 32'(FRAC_MAX), 0, 511);
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd0, 8'd255);
    read_pixel(8'd1, 8'd0);
    drain_pipeline();
    // zero destination width: everything is outside
    set_geometry(1'b0, 0, 0, 0, 256, 1);
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd255, 8'd0);
    drain_pipeline();
    // zero far height: far columns round to an empty column
    set_geometry(1'b1, 0, ONE, ONE / 3, 16, 2);
    for (int x = 0; x < 16; x += 3) read_pixel(XW'(x), 8'd1);
    read_pixel(8'd15, 8'd0);
    drain_pipeline();
    write_reg(REG_UNMAPPED_LO, 32'hFFFF_FFFF);
    write_reg(REG_UNMAPPED_HI, 32'h0000_0001);
    read_pixel(8'd2, 8'd0);
    drain_pipeline();
  endtask

  // one random register setting, mostly small images
  task automatic random_geometry();
    logic [31:0] frac [3];
    logic [31:0] w, h;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(5))
        0: frac[i] = 0;
        1: frac[i] = ONE;
        2: frac[i] = $urandom_range(FRAC_MAX, ONE);
        default: frac[i] = $urandom_range(ONE);
      endcase
    end
    if (frac[1] < ONE / 8 && $urandom_range(1)) frac[1] = $urandom_range(ONE, ONE / 4);
    w = ($urandom_range(5) == 0) ? $urandom_range(511) : $urandom_range(24, 1);
    h = ($urandom_range(5) == 0) ? $urandom_range(511) : $urandom_range(24, 1);
    set_geometry(1'($urandom_range(1)), frac[0], frac[1], frac[2], w, h);
  endtask

  task automatic test_random_stream(input int unsigned phases, input int unsigned per_phase);
    int unsigned dw;
    for (int ph = 0; ph < phases; ph++) begin
      random_geometry();
      dw = dest_width();
      idle_off = (ph % 4 == 3);
      for (int n = 0; n < per_phase; n++) begin
        case ($urandom_range(9))
          0, 1: load_pixel(XW'($urandom()), XW'($urandom()), $urandom());
          2:    read_pixel(XW'($urandom()), XW'($urandom()));
          default: read_pixel(XW'($urandom_range(dw + 1)),
                              XW'($urandom_range(int'(height_q) + 1)));
        endcase
      end
      idle_off = 1'b0;
      drain_pipeline();
    end
  endtask

  // receiver stalls long enough to fill the result fifo and stall requests,
  // then the sender pauses until every result is back
  task automatic test_backpressure();
    set_geometry(1'b0, ONE / 2, ONE / 2, ONE / 4, 64, 64);
    hold_left = HOLD_CYCLES;
    for (int n = 0; n < 120; n++)
      read_pixel(XW'($urandom_range(33)), XW'($urandom_range(63)));
    stop_stream();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 40; n++)
      read_pixel(XW'($urandom_range(31)), XW'($urandom_range(63)));
    drain_pipeline();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    side_right_q = 1'b1;
    amount_q = 64'(AMOUNT_RST);
    shorten_q = 64'(SHORTEN_RST);
    shadow_q = 0;
    width_q = 64'(WIDTH_RST);
    height_q = 64'(HEIGHT_RST);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_shading_extremes();
    test_register_corners();
    test_backpressure();
    test_random_stream(8, 210);

    drain_pipeline();
    $display("covered %0d loads, %0d reads (inside %0d, background %0d, outside %0d)",
             loads_sent, reads_sent, status_seen[ST_INSIDE], status_seen[ST_BACKGROUND],
             status_seen[ST_OUTSIDE]);
    $display("across %0d register writes, %0d pixel results checked", cfg_writes, pixels_seen);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("trapezoid_squeeze_shade_warp_top: match");
    end else begin
      $display("trapezoid_squeeze_shade_warp_top: mismatch");
    end
    $finish;
  end

  // run limit, well past the slowest correct run
  initial begin
    #20ms;
    $display("timeout after %0d results", pixels_seen);
    $display("trapezoid_squeeze_shade_warp_top: mismatch");
    $finish;
  end

endmodule
